// ===== rtl/hsmm_forward_variable_step_macros.svh =====
// Assertion macros for the HSMM forward step block.
`ifndef HSMM_FORWARD_VARIABLE_STEP_MACROS_SVH
`define HSMM_FORWARD_VARIABLE_STEP_MACROS_SVH

// Assert that a condition implies a consequence at the same edge.
`define HSMM_ASSERT_IMPL(label, cond, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
        else $error(msg);

// Assert that a condition implies a consequence at the next edge.
`define HSMM_ASSERT_NEXT(label, cond, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/hsmm_pkg.sv =====
// Shared types, constants and arithmetic helpers for the HSMM forward step block.
package hsmm_pkg;

    localparam int MAX_STATES   = 8;
    localparam int MAX_DURATION = 64;
    localparam int SW = $clog2(MAX_STATES);
    localparam int DW = $clog2(MAX_DURATION);
    localparam int VW = 25;

    localparam logic [VW-1:0] Q_ONE = VW'(24'hFFFFFF) + VW'(1);

    localparam logic [2:0] OP_WR_DUR   = 3'd0;
    localparam logic [2:0] OP_WR_TRANS = 3'd1;
    localparam logic [2:0] OP_WR_PRIOR = 3'd2;
    localparam logic [2:0] OP_RESTART  = 3'd3;
    localparam logic [2:0] OP_TICK     = 3'd4;

    localparam logic [0:0] REG_DUR_LEN = 1'b0;
    localparam logic [0:0] REG_STATES  = 1'b1;

    typedef struct packed {
        logic [2:0]    op;
        logic [2:0]    state_index;
        logic [5:0]    other_index;
        logic [VW-1:0] value;
    } in_beat_t;

    typedef struct packed {
        logic [2:0]    state_number;
        logic [VW-1:0] alpha_value;
        logic          last;
    } out_beat_t;

    // Q1.24 product, truncated
    function automatic logic [VW-1:0] qmul(input logic [VW-1:0] a, input logic [VW-1:0] b);
        logic [2*VW-1:0] p;
        p = a * b;
        return p[VW-1+24:24];
    endfunction

    // Q1.24 sum, saturated at 1.0
    function automatic logic [VW-1:0] qadd(input logic [VW-1:0] a, input logic [VW-1:0] b);
        logic [VW:0] s;
        s = {1'b0, a} + {1'b0, b};
        return (s > {1'b0, Q_ONE}) ? Q_ONE : s[VW-1:0];
    endfunction

endpackage

// ===== rtl/hsmm_mac.sv =====
// Shared registered multiply and saturating add unit.
module hsmm_mac (
    input  logic                  clk,
    input  logic [hsmm_pkg::VW-1:0] mul_a,
    input  logic [hsmm_pkg::VW-1:0] mul_b,
    input  logic [hsmm_pkg::VW-1:0] add_a,
    input  logic                  use_mul,
    output logic [hsmm_pkg::VW-1:0] result
);
    import hsmm_pkg::*;

    logic [VW-1:0] prod;
    logic [VW-1:0] term;

    // one product or a plain operand, then a saturating add
    assign prod = qmul(mul_a, mul_b);
    assign term = use_mul ? prod : mul_b;

    always_ff @(posedge clk)
    begin
        result <= qadd(add_a, term);
    end
endmodule

// ===== rtl/hsmm_forward_variable_step.sv =====
// Top level of the HSMM forward step block: tables, sequencer and ports.
//
// Input channel (in_valid/in_ready, in_beat) takes write, restart and tick
// beats. Writes and restart return nothing. A tick walks the duration-alpha
// matrix in three passes, a memory read state and then an operation state
// per element: the update and the entry sums use one shared multiply-add
// unit, and the row sums add in the sequencer before each result beat.
// The memory read ports and the single multiplier set the length of a tick.
// The output channel (out_valid/out_ready, out_beat) returns N beats per tick,
// state 0 first, last set on state N-1. The sequencer waits on each output
// beat while the receiver stalls; the input channel is not ready during a
// tick. Reset clears the sequencer, the started flag and restores the
// registers to L=64, N=8; tables are undefined until written. Configuration
// goes through an APB port, duration_length at 0x0 and state_count at 0x4,
// written by the user only while the block is idle; the block does not enforce this.
module hsmm_forward_variable_step (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  hsmm_pkg::in_beat_t   in_beat,
    output logic                 out_valid,
    input  logic                 out_ready,
    output hsmm_pkg::out_beat_t  out_beat,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [2:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);
    import hsmm_pkg::*;
    `include "hsmm_forward_variable_step_macros.svh"

    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_UPD   = 7'b0000010,
        ST_UPDW  = 7'b0000100,
        ST_ENT   = 7'b0001000,
        ST_ENTW  = 7'b0010000,
        ST_SUM   = 7'b0100000,
        ST_OUT   = 7'b1000000
    } state_t;

    state_t state_reg, state_next;

    logic [6:0] dlen_reg;
    logic [3:0] scnt_reg;
    logic       started_reg;

    // memories
    logic [VW-1:0] dur_mem   [MAX_STATES*MAX_DURATION];
    logic [VW-1:0] alpha_mem [MAX_STATES*MAX_DURATION];
    logic [VW-1:0] trans_mem [MAX_STATES*MAX_STATES];
    logic [VW-1:0] prior_mem [MAX_STATES];
    logic [VW-1:0] entry_mem [MAX_STATES];

    logic [VW-1:0] dur_rd, alpha_rd, alpha0_rd, trans_rd;
    logic [VW-1:0] prior_q, entry_q;

    // loop counters: i row, d bin, j inner state
    logic [SW-1:0] i_reg;
    logic [DW-1:0] d_reg;
    logic [SW-1:0] j_reg;
    logic [VW-1:0] acc_reg;
    logic          init_reg;

    // clamped registers
    logic [DW:0]   len;
    logic [SW:0]   n;
    always_comb
    begin
        if (dlen_reg < 7'd2)
            len = (DW+1)'(2);
        else if (dlen_reg > 7'(MAX_DURATION))
            len = (DW+1)'(MAX_DURATION);
        else
            len = dlen_reg[DW:0];
        if (scnt_reg < 4'd1)
            n = (SW+1)'(1);
        else if (scnt_reg > 4'(MAX_STATES))
            n = (SW+1)'(MAX_STATES);
        else
            n = scnt_reg[SW:0];
    end

    logic last_d, last_i, last_j;
    assign last_d = ({1'b0, d_reg} == len - (DW+1)'(1));
    assign last_i = ({1'b0, i_reg} == n - (SW+1)'(1));
    assign last_j = ({1'b0, j_reg} == n - (SW+1)'(1));

    // shared unit
    logic [VW-1:0] mul_a, mul_b, add_a, mac_out;
    logic          use_mul;
    hsmm_mac u_mac (
        .clk    (clk),
        .mul_a  (mul_a),
        .mul_b  (mul_b),
        .add_a  (add_a),
        .use_mul(use_mul),
        .result (mac_out)
    );

    always_comb
    begin
        mul_a   = dur_rd;
        mul_b   = alpha_rd;
        add_a   = '0;
        use_mul = 1'b1;
        unique case (state_reg)
            ST_UPDW:
            begin
                if (init_reg)
                    mul_b = prior_q;
                else
                begin
                    mul_b = entry_q;
                    add_a = last_d ? '0 : alpha_rd;
                end
            end
            ST_ENTW:
            begin
                // first source starts a fresh sum
                mul_a = trans_rd;
                mul_b = alpha0_rd;
                add_a = (j_reg == '0) ? '0 : acc_reg;
            end
            ST_OUT:
            begin
                mul_b   = alpha_rd;
                add_a   = acc_reg;
                use_mul = 1'b0;
            end
            default: ;
        endcase
    end

    logic in_fire, out_fire, cfg_wr;
    assign in_ready = (state_reg == ST_IDLE);
    assign in_fire  = in_valid && in_ready;
    assign out_fire = out_valid && out_ready;
    assign pready   = 1'b1;
    assign cfg_wr   = psel && penable && pwrite;

    // write-side decode
    logic [VW-1:0] wval;
    assign wval = (in_beat.value > Q_ONE) ? Q_ONE : in_beat.value;

    // sum phase: ST_SUM issues read of bin d, ST_OUT adds it; out beat held
    logic [SW+DW-1:0] alpha_waddr;

    // memory ports
    logic [SW+DW-1:0] rd_addr_a, rd_addr_b;
    logic             wr_upd_reg;
    logic             ent_wr_reg;
    logic [SW+DW-1:0] wr_addr_reg;
    always_comb
    begin
        rd_addr_a = {i_reg, d_reg};
        rd_addr_b = {j_reg, {DW{1'b0}}};
    end
    assign alpha_waddr = wr_addr_reg;

    always_ff @(posedge clk)
    begin
        if (in_fire && in_beat.op == OP_WR_DUR)
            dur_mem[{in_beat.state_index[SW-1:0], in_beat.other_index[DW-1:0]}] <= wval;
        dur_rd <= dur_mem[rd_addr_a];
    end

    always_ff @(posedge clk)
    begin
        if (wr_upd_reg)
            alpha_mem[alpha_waddr] <= mac_out;
        alpha_rd  <= alpha_mem[(state_reg == ST_UPD && !last_d) ? rd_addr_a + 1'b1 : rd_addr_a];
        alpha0_rd <= alpha_mem[rd_addr_b];
    end

    // entry sum is written in the cycle after its last source, row index from wr_addr_reg
    always_ff @(posedge clk)
    begin
        if (in_fire && in_beat.op == OP_WR_TRANS && in_beat.other_index < 6'(MAX_STATES))
            trans_mem[{in_beat.state_index[SW-1:0], in_beat.other_index[SW-1:0]}] <= wval;
        trans_rd <= trans_mem[{j_reg, i_reg}];
        if (in_fire && in_beat.op == OP_WR_PRIOR)
            prior_mem[in_beat.state_index[SW-1:0]] <= wval;
        prior_q <= prior_mem[i_reg];
        entry_q <= entry_mem[i_reg];
        if (ent_wr_reg)
            entry_mem[wr_addr_reg[SW+DW-1:DW]] <= mac_out;
    end

    // sequencer; in ST_ENTW, i_reg is the destination and j_reg the source
    logic [SW-1:0] i_next, j_next;
    logic [DW-1:0] d_next;
    logic [VW-1:0] acc_next;
    logic          wr_upd_next;
    logic          ent_wr_next;
    logic          out_valid_reg, out_valid_next;
    always_comb
    begin
        state_next     = state_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        d_next         = d_reg;
        acc_next       = acc_reg;
        wr_upd_next    = 1'b0;
        ent_wr_next    = 1'b0;
        out_valid_next = out_valid_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire && in_beat.op == OP_TICK)
                begin
                    state_next = ST_UPD;
                    i_next     = '0;
                    d_next     = '0;
                end
            end
            ST_UPD:
                state_next = ST_UPDW;
            ST_UPDW:
            begin
                wr_upd_next = 1'b1;
                state_next  = ST_UPD;
                if (last_d)
                begin
                    d_next = '0;
                    if (last_i)
                    begin
                        i_next     = '0;
                        j_next     = '0;
                        acc_next   = '0;
                        state_next = ST_ENT;
                    end
                    else
                        i_next = i_reg + 1'b1;
                end
                else
                    d_next = d_reg + 1'b1;
            end
            ST_ENT:
            begin
                // running sum of the previous source returns from the unit
                acc_next   = mac_out;
                state_next = ST_ENTW;
            end
            ST_ENTW:
            begin
                state_next = ST_ENT;
                if (last_j)
                begin
                    ent_wr_next = 1'b1;
                    acc_next    = '0;
                    j_next      = '0;
                    if (last_i)
                    begin
                        i_next     = '0;
                        d_next     = '0;
                        state_next = ST_SUM;
                    end
                    else
                        i_next = i_reg + 1'b1;
                end
                else
                    j_next = j_reg + 1'b1;
            end
            ST_SUM:
                state_next = ST_OUT;
            ST_OUT:
            begin
                if (!out_valid_reg)
                begin
                    acc_next = qadd(acc_reg, alpha_rd);
                    if (last_d)
                        out_valid_next = 1'b1;
                    else
                    begin
                        d_next     = d_reg + 1'b1;
                        state_next = ST_SUM;
                    end
                end
                else if (out_fire)
                begin
                    out_valid_next = 1'b0;
                    acc_next       = '0;
                    d_next         = '0;
                    if (last_i)
                        state_next = ST_IDLE;
                    else
                    begin
                        i_next     = i_reg + 1'b1;
                        state_next = ST_SUM;
                    end
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            wr_upd_reg    <= 1'b0;
            ent_wr_reg    <= 1'b0;
            started_reg   <= 1'b0;
            init_reg      <= 1'b0;
            dlen_reg      <= 7'd64;
            scnt_reg      <= 4'd8;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            wr_upd_reg    <= wr_upd_next;
            ent_wr_reg    <= ent_wr_next;
            if (in_fire && in_beat.op == OP_RESTART)
                started_reg <= 1'b0;
            if (in_fire && in_beat.op == OP_TICK)
            begin
                init_reg    <= !started_reg;
                started_reg <= 1'b1;
            end
            if (cfg_wr && paddr[2] == REG_DUR_LEN && paddr[1:0] == 2'b00)
                dlen_reg <= pwdata[6:0];
            if (cfg_wr && paddr[2] == REG_STATES && paddr[1:0] == 2'b00)
                scnt_reg <= pwdata[3:0];
        end
    end

    always_ff @(posedge clk)
    begin
        i_reg       <= i_next;
        j_reg       <= j_next;
        d_reg       <= d_next;
        acc_reg     <= acc_next;
        wr_addr_reg <= {i_reg, d_reg};
    end

    // register read-back
    always_comb
    begin
        prdata = '0;
        if (paddr == {REG_DUR_LEN, 2'b00})
            prdata = {25'd0, dlen_reg};
        else if (paddr == {REG_STATES, 2'b00})
            prdata = {28'd0, scnt_reg};
    end

    assign out_valid              = out_valid_reg;
    assign out_beat.state_number  = 3'(i_reg);
    assign out_beat.alpha_value   = acc_reg;
    assign out_beat.last          = last_i;

    `HSMM_ASSERT_IMPL(a_busy_no_ready, state_reg != ST_IDLE, !in_ready,
        "input ready while a tick is in progress")
    `HSMM_ASSERT_IMPL(a_out_only_in_out, out_valid, state_reg == ST_OUT,
        "result beat outside the report phase")
    `HSMM_ASSERT_NEXT(a_out_holds, out_valid && !out_ready, out_valid && $stable(acc_reg),
        "result beat changed while stalled")
    `HSMM_ASSERT_IMPL(a_acc_sat, out_valid, out_beat.alpha_value <= Q_ONE,
        "forward value above 1.0")
endmodule

// ===== tb/tb_hsmm_forward_variable_step.sv =====
// Self-checking testbench for the HSMM forward step block: stimulus, prediction and checks.
module tb_hsmm_forward_variable_step;
    import hsmm_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int LONG_HOLD      = 600;
    localparam int SETTLE         = 60;

    typedef struct {
        in_beat_t beat;
        bit       drain;
    } pending_item_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    in_beat_t    in_beat;
    logic        out_valid;
    logic        out_ready;
    out_beat_t   out_beat;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    hsmm_forward_variable_step DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_beat  (in_beat),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_beat (out_beat),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    pending_item_t pending_beats[$];
    out_beat_t     alpha_expected[$];
    int            error_count;
    bit            tight;
    bit            long_hold_req;
    bit            in_took;
    bit            out_took;
    int            idle_cycles;

    // predictor state, updated at input acceptance
    logic [VW-1:0] dur_model[MAX_STATES][MAX_DURATION];
    logic [VW-1:0] trans_model[MAX_STATES][MAX_STATES];
    logic [VW-1:0] prior_model[MAX_STATES];
    logic [VW-1:0] alpha_model[MAX_STATES][MAX_DURATION];
    logic [VW-1:0] entry_model[MAX_STATES];
    bit            chain_started;
    logic [6:0]    len_reg;
    logic [3:0]    count_reg;

    // generator view of which table entries hold data
    bit dur_set[MAX_STATES][MAX_DURATION];
    bit trans_set[MAX_STATES][MAX_STATES];
    bit prior_set[MAX_STATES];
    int gen_len;
    int gen_count;

    // clock
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic logic [VW-1:0] prob_mul(input logic [VW-1:0] a, input logic [VW-1:0] b);
        logic [2*VW-1:0] p;
        p = a * b;
        return p[VW-1+24:24];
    endfunction

    function automatic logic [VW-1:0] prob_add(input logic [VW-1:0] a, input logic [VW-1:0] b);
        logic [VW:0] s;
        s = {1'b0, a} + {1'b0, b};
        return (s > {1'b0, Q_ONE}) ? Q_ONE : s[VW-1:0];
    endfunction

    function automatic int eff_len(input int raw);
        return raw < 2 ? 2 : (raw > MAX_DURATION ? MAX_DURATION : raw);
    endfunction

    function automatic int eff_count(input int raw);
        return raw < 1 ? 1 : (raw > MAX_STATES ? MAX_STATES : raw);
    endfunction

    // apply one accepted beat to the predictor, queue the alphas a tick yields
    task automatic predict_forward(input in_beat_t b);
        logic [VW-1:0] v;
        logic [VW-1:0] acc;
        logic [VW-1:0] s;
        int len;
        int n;
        out_beat_t r;
        v = (b.value > Q_ONE) ? Q_ONE : b.value;
        case (b.op)
            OP_WR_DUR:   dur_model[b.state_index][b.other_index] = v;
            OP_WR_TRANS: if (b.other_index < MAX_STATES) trans_model[b.state_index][b.other_index] = v;
            OP_WR_PRIOR: prior_model[b.state_index] = v;
            OP_RESTART:  chain_started = 1'b0;
            OP_TICK:
            begin
                len = eff_len(int'(len_reg));
                n = eff_count(int'(count_reg));
                for (int i = 0; i < n; i++)
                begin
                    if (!chain_started)
                    begin
                        for (int d = 0; d < len; d++)
                            alpha_model[i][d] = prob_mul(prior_model[i], dur_model[i][d]);
                    end
                    else
                    begin
                        s = entry_model[i];
                        for (int d = 0; d + 1 < len; d++)
                            alpha_model[i][d] = prob_add(alpha_model[i][d+1],
                                                         prob_mul(s, dur_model[i][d]));
                        alpha_model[i][len-1] = prob_mul(s, dur_model[i][len-1]);
                    end
                end
                chain_started = 1'b1;
                for (int j = 0; j < n; j++)
                begin
                    acc = '0;
                    for (int i = 0; i < n; i++)
                        acc = prob_add(acc, prob_mul(trans_model[i][j], alpha_model[i][0]));
                    entry_model[j] = acc;
                end
                for (int i = 0; i < n; i++)
                begin
                    acc = '0;
                    for (int d = 0; d < len; d++)
                        acc = prob_add(acc, alpha_model[i][d]);
                    r.state_number = i[2:0];
                    r.alpha_value = acc;
                    r.last = (i + 1 == n);
                    alpha_expected = {alpha_expected, r};
                end
            end
            default: ;
        endcase
    endtask

    // queue one beat and note what it writes
    task automatic push_beat(input logic [2:0] op, input int si, input int oi,
                             input logic [VW-1:0] v, input bit drain);
        pending_item_t p;
        p.beat.op = op;
        p.beat.state_index = si[2:0];
        p.beat.other_index = oi[5:0];
        p.beat.value = v;
        p.drain = drain;
        pending_beats = {pending_beats, p};
        case (op)
            OP_WR_DUR:   dur_set[si][oi] = 1'b1;
            OP_WR_TRANS: if (oi < MAX_STATES) trans_set[si][oi] = 1'b1;
            OP_WR_PRIOR: prior_set[si] = 1'b1;
            default: ;
        endcase
    endtask

    function automatic logic [VW-1:0] draw_prob();
        case ($urandom_range(0, 4))
            0: return Q_ONE;
            1: return VW'($urandom_range(0, Q_ONE));
            2: return VW'($urandom());
            3: return VW'($urandom_range(0, 24'h3FFFFF));
            default: return VW'($urandom_range(0, 24'h0FFFFF));
        endcase
    endfunction

    // a tick preceded by writes for any entry it would read unwritten
    task automatic push_tick(input bit drain);
        for (int i = 0; i < gen_count; i++)
        begin
            if (!prior_set[i])
                push_beat(OP_WR_PRIOR, i, $urandom_range(0, 63), draw_prob(), 1'b0);
            for (int d = 0; d < gen_len; d++)
                if (!dur_set[i][d])
                    push_beat(OP_WR_DUR, i, d, draw_prob(), 1'b0);
            for (int j = 0; j < gen_count; j++)
                if (!trans_set[i][j])
                    push_beat(OP_WR_TRANS, i, j, draw_prob(), 1'b0);
        end
        push_beat(OP_TICK, $urandom_range(0, 7), $urandom_range(0, 63), VW'($urandom()), drain);
    endtask

    task automatic push_random_beat();
        int k;
        k = $urandom_range(0, 99);
        if (k < 35)
            push_tick($urandom_range(0, 39) == 0);
        else if (k < 55)
            push_beat(OP_WR_DUR, $urandom_range(0, 7), $urandom_range(0, 63), draw_prob(), 1'b0);
        else if (k < 75)
            push_beat(OP_WR_TRANS, $urandom_range(0, 7), $urandom_range(0, 63), draw_prob(), 1'b0);
        else if (k < 85)
            push_beat(OP_WR_PRIOR, $urandom_range(0, 7), $urandom_range(0, 63), draw_prob(), 1'b0);
        else if (k < 92)
            push_beat(OP_RESTART, $urandom_range(0, 7), $urandom_range(0, 63),
                      VW'($urandom()), 1'b0);
        else
            push_beat(3'($urandom_range(5, 7)), $urandom_range(0, 7), $urandom_range(0, 63),
                      VW'($urandom()), 1'b0);
    endtask

    task automatic wait_idle();
        while (pending_beats.size() != 0 || in_valid || alpha_expected.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic reg_write(input logic [0:0] idx, input logic [31:0] data);
        @(negedge clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= {idx, 2'b00};
        pwdata <= data;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (idx == REG_DUR_LEN)
            len_reg = data[6:0];
        else
            count_reg = data[3:0];
    endtask

    // input driver
    int send_gap;
    always @(negedge clk)
    begin
        if (!(in_valid && !in_took))
        begin
            if (send_gap > 0)
            begin
                send_gap--;
                in_valid <= 1'b0;
            end
            else if (pending_beats.size() != 0 &&
                     !(pending_beats[0].drain && alpha_expected.size() != 0))
            begin
                in_beat <= pending_beats[0].beat;
                in_valid <= 1'b1;
                void'(pending_beats.pop_front());
                send_gap = tight ? 0 : $urandom_range(0, 16);
            end
            else
                in_valid <= 1'b0;
        end
    end

    // output ready driver
    int hold_left;
    always @(negedge clk)
    begin
        if (out_took)
        begin
            if (long_hold_req)
            begin
                hold_left = LONG_HOLD;
                long_hold_req = 1'b0;
            end
            else
                hold_left = tight ? 0 : $urandom_range(0, 16);
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_ready <= 1'b0;
        end
        else
            out_ready <= 1'b1;
    end

    // prediction on input beats, checking on output beats
    always @(posedge clk)
    begin
        out_beat_t want;
        in_took <= in_valid && in_ready;
        out_took <= out_valid && out_ready;
        if (rst_n && in_valid && in_ready)
            predict_forward(in_beat);
        if (rst_n && out_valid && out_ready)
        begin
            if (alpha_expected.size() == 0)
            begin
                $error("alpha beat with nothing expected: state %0d value %0d",
                       out_beat.state_number, out_beat.alpha_value);
                error_count++;
            end
            else
            begin
                want = alpha_expected.pop_front();
                if (out_beat.state_number !== want.state_number)
                begin
                    $error("state_number expected %0d got %0d",
                           want.state_number, out_beat.state_number);
                    error_count++;
                end
                if (out_beat.alpha_value !== want.alpha_value)
                begin
                    $error("alpha_value expected %0d got %0d",
                           want.alpha_value, out_beat.alpha_value);
                    error_count++;
                end
                if (out_beat.last !== want.last)
                begin
                    $error("last expected %0d got %0d", want.last, out_beat.last);
                    error_count++;
                end
            end
        end
    end

    // watchdog on cycles with no beat moving
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("tb_hsmm_forward_variable_step: done, errors");
            $finish;
        end
    end

    // stimulus sequence; table fill writes before ticks make up much of the count
    int phase_len[7]   = '{4, 0, 127, 5, 2, 64, 9};
    int phase_count[7] = '{2, 0, 1, 3, 15, 1, 4};
    int phase_beats[7] = '{6, 6, 3, 8, 6, 4, 7};
    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_beat = '0;
        out_ready = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        error_count = 0;
        tight = 1'b0;
        long_hold_req = 1'b0;
        in_took = 1'b0;
        out_took = 1'b0;
        idle_cycles = 0;
        send_gap = 0;
        hold_left = 0;
        chain_started = 1'b0;
        len_reg = 7'd64;
        count_reg = 4'd8;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        for (int p = 0; p < 7; p++)
        begin
            wait_idle();
            tight = (p % 3 == 1);
            reg_write(REG_DUR_LEN, {$urandom() & 32'hFFFF_FF80} | phase_len[p]);
            reg_write(REG_STATES, {$urandom() & 32'hFFFF_FFF0} | phase_count[p]);
            gen_len = eff_len(phase_len[p]);
            gen_count = eff_count(phase_count[p]);
            // new sizes: start the chain over
            push_beat(OP_RESTART, 0, 0, '0, 1'b0);
            if (p == 0)
            begin
                // field extremes, every op, clipping and ignored writes
                push_beat(OP_WR_PRIOR, 0, 63, Q_ONE, 1'b0);
                push_beat(OP_WR_PRIOR, 1, 0, {VW{1'b1}}, 1'b0);
                push_beat(OP_WR_PRIOR, 7, 21, '0, 1'b0);
                push_beat(OP_WR_DUR, 0, 0, {VW{1'b1}}, 1'b0);
                push_beat(OP_WR_DUR, 7, 63, 25'h0AAAAAA, 1'b0);
                push_beat(OP_WR_DUR, 1, 1, 25'h1555555, 1'b0);
                push_beat(OP_WR_TRANS, 0, 1, Q_ONE, 1'b0);
                push_beat(OP_WR_TRANS, 1, 63, 25'd12345, 1'b0);
                push_beat(OP_WR_TRANS, 7, 7, 25'd0, 1'b0);
                push_beat(3'd5, 7, 63, {VW{1'b1}}, 1'b0);
                push_beat(3'd6, 2, 42, 25'd1, 1'b0);
                push_beat(3'd7, 5, 21, '0, 1'b0);
                push_tick(1'b0);
                push_tick(1'b0);
                push_tick(1'b1);
                push_beat(OP_RESTART, 7, 63, {VW{1'b1}}, 1'b0);
                push_tick(1'b0);
                push_tick(1'b0);
            end
            if (p == 3)
                long_hold_req = 1'b1;
            for (int k = 0; k < phase_beats[p]; k++)
                push_random_beat();
            push_tick(1'b0);
        end

        wait_idle();
        repeat (SETTLE) @(posedge clk);
        if (alpha_expected.size() != 0)
        begin
            $error("%0d alpha beats never arrived", alpha_expected.size());
            error_count++;
        end
        if (error_count == 0)
            $display("tb_hsmm_forward_variable_step: done, clean");
        else
            $display("tb_hsmm_forward_variable_step: done, errors");
        $finish;
    end
endmodule
